FILE: rtl/nsrc_pkg.sv
// Shared widths, register indexes, controller states and command/status types.
package nsrc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 13;
    localparam int COUNT_W  = 24;
    localparam int PHASE_W  = 32;
    localparam int FRAC_W   = 8;
    localparam int PEAK_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_RES    = 64;
    localparam int RES_CNT_W  = $clog2(MAX_RES) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT    = 2'd2;

    localparam logic [STEP_W-1:0]  FRAC_STEP_RST = 13'd256;
    localparam logic [7:0]         BYTE_OFFSET   = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK_FIRST,
        S_UPDATE,
        S_CHECK,
        S_SEND_MID,
        S_SEND_LAST
    } t_state;

    typedef struct packed {
        logic load_in;
        logic update;
        logic send;
        logic last;
        logic incr_src;
    } t_dp_cmd;

    typedef struct packed {
        logic due;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/nsrc_in_if.sv
// Source sample channel.
interface nsrc_in_if;
    logic                             valid;
    logic                             ready;
    logic [nsrc_pkg::SAMPLE_W-1:0]    raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

FILE: rtl/nsrc_out_if.sv
// Converted sample channel.
interface nsrc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [nsrc_pkg::SAMPLE_W-1:0] pcm_out;
    logic [nsrc_pkg::PEAK_W-1:0]         peak_level;
    logic                                run_last;
    logic                                stream_done;

    modport source (output valid, output pcm_out, output peak_level, output run_last,
                    output stream_done, input ready);
    modport sink   (input valid, input pcm_out, input peak_level, input run_last,
                    input stream_done, output ready);
endinterface

FILE: rtl/nsrc_ctrl.sv
// Sequencer: accept a sample, then check, update and send one output at a time.
module nsrc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nsrc_pkg::t_dp_sts  i_sts,
    output nsrc_pkg::t_dp_cmd  o_cmd
);

    nsrc_pkg::t_state r_state;
    nsrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            nsrc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = nsrc_pkg::S_CHECK_FIRST;
                end
            end
            nsrc_pkg::S_CHECK_FIRST: begin
                if (i_sts.due) begin
                    n_state = nsrc_pkg::S_UPDATE;
                end else begin
                    o_cmd.incr_src = 1'b1;
                    n_state        = nsrc_pkg::S_IDLE;
                end
            end
            nsrc_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = nsrc_pkg::S_CHECK;
            end
            nsrc_pkg::S_CHECK: begin
                n_state = i_sts.due ? nsrc_pkg::S_SEND_MID : nsrc_pkg::S_SEND_LAST;
            end
            nsrc_pkg::S_SEND_MID: begin
                if (i_sts.out_free) begin
                    o_cmd.send = 1'b1;
                    n_state    = nsrc_pkg::S_UPDATE;
                end
            end
            nsrc_pkg::S_SEND_LAST: begin
                if (i_sts.out_free) begin
                    o_cmd.send     = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.incr_src = 1'b1;
                    n_state        = nsrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nsrc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/nsrc_dp.sv
// Datapath: configuration, phase accumulator, counters, peak hold and output register.
module nsrc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [nsrc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nsrc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [nsrc_pkg::SAMPLE_W-1:0]         i_raw_sample,
    input  nsrc_pkg::t_dp_cmd                     i_cmd,
    output nsrc_pkg::t_dp_sts                     o_sts,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [nsrc_pkg::SAMPLE_W-1:0]  o_pcm_out,
    output logic [nsrc_pkg::PEAK_W-1:0]           o_peak_level,
    output logic                                  o_run_last,
    output logic                                  o_stream_done
);

    logic [nsrc_pkg::STEP_W-1:0]    r_frac_step;
    logic                           r_wide_samples;
    logic [nsrc_pkg::COUNT_W-1:0]   r_out_count;

    logic [nsrc_pkg::PHASE_W-1:0]   r_phase_acc;
    logic [nsrc_pkg::COUNT_W-1:0]   r_source_index;
    logic [nsrc_pkg::COUNT_W-1:0]   r_outputs_done;
    logic [nsrc_pkg::PEAK_W-1:0]    r_peak_hold;
    logic [nsrc_pkg::RES_CNT_W-1:0] r_res_cnt;

    logic [nsrc_pkg::SAMPLE_W-1:0]  r_word;
    logic [nsrc_pkg::PEAK_W-1:0]    r_level;

    logic [nsrc_pkg::SAMPLE_W-1:0]  r_pend_word;
    logic [nsrc_pkg::PEAK_W-1:0]    r_pend_peak;
    logic                           r_pend_done;

    logic                           r_out_valid;
    logic [nsrc_pkg::SAMPLE_W-1:0]  r_out_word;
    logic [nsrc_pkg::PEAK_W-1:0]    r_out_peak;
    logic                           r_out_last;
    logic                           r_out_done;

    logic [nsrc_pkg::SAMPLE_W-1:0]  n_word;
    logic [nsrc_pkg::SAMPLE_W:0]    n_mag;
    logic [nsrc_pkg::PEAK_W-1:0]    n_level;
    logic [nsrc_pkg::PEAK_W-1:0]    n_peak;
    logic [nsrc_pkg::COUNT_W-1:0]   n_outputs_done;
    logic [nsrc_pkg::COUNT_W-1:0]   n_lag;

    always_comb begin
        if (r_wide_samples) begin
            n_word = i_raw_sample;
        end else begin
            n_word = {i_raw_sample[7:0] ^ nsrc_pkg::BYTE_OFFSET, 8'h00};
        end
        if (n_word[nsrc_pkg::SAMPLE_W-1]) begin
            n_mag = (nsrc_pkg::SAMPLE_W+1)'(1) << nsrc_pkg::SAMPLE_W;
            n_mag = n_mag - {1'b0, n_word};
        end else begin
            n_mag = {1'b0, n_word};
        end
        n_level = n_mag[nsrc_pkg::FRAC_W +: nsrc_pkg::PEAK_W];
    end

    assign n_peak         = (r_level > r_peak_hold) ? r_level : r_peak_hold;
    assign n_outputs_done = r_outputs_done + 1'b1;
    assign n_lag          = r_source_index
                          - r_phase_acc[nsrc_pkg::FRAC_W +: nsrc_pkg::COUNT_W];

    assign o_sts.due      = !r_res_cnt[nsrc_pkg::RES_CNT_W-1]
                          && (r_outputs_done < r_out_count)
                          && !n_lag[nsrc_pkg::COUNT_W-1];
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_step    <= nsrc_pkg::FRAC_STEP_RST;
            r_wide_samples <= 1'b1;
            r_out_count    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                nsrc_pkg::CFG_FRAC_STEP:    r_frac_step    <= i_cfg_data[nsrc_pkg::STEP_W-1:0];
                nsrc_pkg::CFG_WIDE_SAMPLES: r_wide_samples <= i_cfg_data[0];
                nsrc_pkg::CFG_OUT_COUNT:    r_out_count    <= i_cfg_data[nsrc_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_source_index <= '0;
            r_outputs_done <= '0;
            r_peak_hold    <= '0;
            r_res_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_res_cnt <= '0;
            end
            if (i_cmd.update) begin
                r_peak_hold    <= n_peak;
                r_phase_acc    <= r_phase_acc + {{(nsrc_pkg::PHASE_W-nsrc_pkg::STEP_W){1'b0}},
                                                 r_frac_step};
                r_outputs_done <= n_outputs_done;
                r_res_cnt      <= r_res_cnt + 1'b1;
            end
            if (i_cmd.incr_src) begin
                r_source_index <= r_source_index + 1'b1;
            end
            if (i_cmd.send) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_word  <= n_word;
            r_level <= n_level;
        end
        if (i_cmd.update) begin
            r_pend_word <= r_word;
            r_pend_peak <= n_peak;
            r_pend_done <= (n_outputs_done == r_out_count);
        end
        if (i_cmd.send) begin
            r_out_word <= r_pend_word;
            r_out_peak <= r_pend_peak;
            r_out_last <= i_cmd.last;
            r_out_done <= r_pend_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pcm_out     = $signed(r_out_word);
    assign o_peak_level  = r_out_peak;
    assign o_run_last    = r_out_last;
    assign o_stream_done = r_out_done;

endmodule

FILE: rtl/nearest_sample_rate_converter.sv
// Nearest-neighbor sample rate converter top level.
// Each accepted source sample is repeated zero or more times: output i takes the
// source sample whose index is (i * frac_step) >> 8, frac_step being unsigned 5.8,
// until out_count outputs have been produced; at most 64 outputs leave per input,
// with any remainder drawn from later inputs. 8-bit input bytes are recentered and
// widened to 16 bits. Every output carries the running peak of |sample| >> 8, a flag
// on the last output of its input, and a flag on the final output of the stream.
// An input holds the block until its last output is handed over, and longer while the
// output channel stalls; the controller checks, advances the phase accumulator and
// hands over one output per pass.
// The output register lets a result wait while the next one is being formed.
// Write configuration only while no input is in flight.
module nearest_sample_rate_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [nsrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nsrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    nsrc_in_if.sink                           i_smp,
    nsrc_out_if.source                        o_res
);

    nsrc_pkg::t_dp_cmd dp_cmd;
    nsrc_pkg::t_dp_sts dp_sts;

    nsrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    nsrc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_raw_sample  (i_smp.raw_sample),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_pcm_out     (o_res.pcm_out),
        .o_peak_level  (o_res.peak_level),
        .o_run_last    (o_res.run_last),
        .o_stream_done (o_res.stream_done)
    );

endmodule
